FILE: hw/rtl/hcbd_pkg.sv
// Shared widths, word layouts and result type of the chunked body decoder.
package hcbd_pkg;

	localparam int unsigned SIZE_BITS   = 32;
	localparam int unsigned LENGTH_BITS = 32;
	localparam int unsigned BYTE_BITS   = 8;
	localparam int unsigned BLEN_BITS   = 32;

	// Output tdata: data_byte, body_length, overflow, padded to whole bytes.
	localparam int unsigned RES_BITS   = BYTE_BITS + BLEN_BITS + 1;
	localparam int unsigned M_DATA_BITS = ((RES_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic                 restart;
		logic [BYTE_BITS-1:0] in_byte;
	} in_word_t;

	typedef struct packed {
		logic                 overflow;
		logic [BLEN_BITS-1:0] body_length;
		logic                 last;
		logic                 is_data;
		logic [BYTE_BITS-1:0] data_byte;
	} res_word_t;

endpackage

FILE: hw/rtl/hcbd_in_stage.sv
// Input register stage: holds one accepted word until the decoder takes it.
module hcbd_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hcbd_pkg::in_word_t in_word,
	output logic               valid_s1,
	output hcbd_pkg::in_word_t word_s1,
	input  logic               take
);

	logic fire;

	assign in_ready = !valid_s1 || take;
	assign fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			word_s1 <= in_word;
		end
	end

endmodule

FILE: hw/rtl/hcbd_core.sv
// Chunk framing state and per-byte decode: size line, data, trailer, end wait.
module hcbd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  hcbd_pkg::in_word_t  word,
	output logic                res_valid,
	output hcbd_pkg::res_word_t res
);

	localparam logic [2:0] PH_BLANK   = 3'd0;
	localparam logic [2:0] PH_LINE    = 3'd1;
	localparam logic [2:0] PH_DATA    = 3'd2;
	localparam logic [2:0] PH_TRAIL   = 3'd3;
	localparam logic [2:0] PH_ENDWAIT = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [1:0] SKIP_RELOAD = 2'd2;

	localparam int unsigned SB = hcbd_pkg::SIZE_BITS;
	localparam int unsigned LB = hcbd_pkg::LENGTH_BITS;

	logic [2:0]    phase_q, phase_n;
	logic [SB-1:0] chunk_q, chunk_n;
	logic          seen_q, seen_n;
	logic          closed_q, closed_n;
	logic          cr_q, cr_n;
	logic [1:0]    skip_q, skip_n;
	logic [LB-1:0] count_q, count_n;
	logic          ovf_q, ovf_n;

	logic [7:0] b;
	logic       b_blank;
	logic [4:0] hex;

	// Bit 4: byte is a hex digit; bits 3:0: its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	assign b       = word.in_byte;
	assign hex     = hex_decode(b);
	assign b_blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);

	always_comb begin
		phase_n  = phase_q;
		chunk_n  = chunk_q;
		seen_n   = seen_q;
		closed_n = closed_q;
		cr_n     = cr_q;
		skip_n   = skip_q;
		count_n  = count_q;
		ovf_n    = ovf_q;
		if (word.restart) begin
			phase_n  = PH_BLANK;
			chunk_n  = '0;
			seen_n   = 1'b0;
			closed_n = 1'b0;
			cr_n     = 1'b0;
			skip_n   = '0;
			count_n  = '0;
			ovf_n    = 1'b0;
		end
		res_valid = 1'b0;
		res       = '0;

		unique case (phase_n)
			PH_BLANK, PH_LINE: begin
				if (cr_n && b == CH_LF) begin
					cr_n = 1'b0;
					if (!seen_n || chunk_n == '0) begin
						phase_n = PH_ENDWAIT;
						skip_n  = SKIP_RELOAD;
					end else begin
						phase_n = PH_DATA;
					end
				end else begin
					cr_n = (b == CH_CR);
					if (!(phase_n == PH_BLANK && b_blank)) begin
						phase_n = PH_LINE;
						if (!closed_n && hex[4]) begin
							seen_n = 1'b1;
							if (|chunk_n[SB-1 -: 4]) begin
								chunk_n = '1;
								ovf_n   = 1'b1;
							end else begin
								chunk_n = {chunk_n[SB-5:0], hex[3:0]};
							end
						end else begin
							closed_n = 1'b1;
						end
					end
				end
			end
			PH_DATA: begin
				if (count_n != '1) begin
					count_n = count_n + LB'(1);
				end
				res_valid       = 1'b1;
				res.data_byte   = b;
				res.is_data     = 1'b1;
				res.body_length = hcbd_pkg::BLEN_BITS'(count_n);
				res.overflow    = ovf_n;
				chunk_n         = chunk_n - SB'(1);
				if (chunk_n == '0) begin
					phase_n = PH_TRAIL;
					skip_n  = SKIP_RELOAD;
				end
			end
			PH_TRAIL: begin
				skip_n = skip_n - 2'd1;
				if (skip_n == '0) begin
					phase_n  = PH_BLANK;
					chunk_n  = '0;
					seen_n   = 1'b0;
					closed_n = 1'b0;
					cr_n     = 1'b0;
				end
			end
			PH_ENDWAIT: begin
				skip_n = skip_n - 2'd1;
				if (skip_n == '0) begin
					phase_n         = PH_DONE;
					res_valid       = 1'b1;
					res.last        = 1'b1;
					res.body_length = hcbd_pkg::BLEN_BITS'(count_n);
					res.overflow    = ovf_n;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BLANK;
			chunk_q  <= '0;
			seen_q   <= 1'b0;
			closed_q <= 1'b0;
			cr_q     <= 1'b0;
			skip_q   <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			chunk_q  <= chunk_n;
			seen_q   <= seen_n;
			closed_q <= closed_n;
			cr_q     <= cr_n;
			skip_q   <= skip_n;
			count_q  <= count_n;
			ovf_q    <= ovf_n;
		end
	end

endmodule

FILE: hw/rtl/hcbd_out_stage.sv
// Result register: holds one result word until the sink takes it.
module hcbd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  hcbd_pkg::res_word_t res,
	output logic                room,
	output logic                valid_s2,
	output hcbd_pkg::res_word_t word_s2,
	input  logic                out_ready
);

	assign room = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (room) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			word_s2 <= res;
		end
	end

endmodule

FILE: hw/rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: input stage, decoder, result register.
//
//  channel   | dir | tdata (low bit up)                         | tuser    | tlast
//  s_axis    | in  | in_byte[7:0]                               | restart  | -
//  m_axis    | out | data_byte[7:0], body_length[39:8],         | is_data  | last
//            |     | overflow[40], zero pad[47:41]              |          |
//
// One word per cycle sustained while the sink keeps taking results; each accepted
// word is registered in the input register, then its result is loaded into the
// result register, which holds the result until the sink takes it.
// Reset clears the framing state to the start of a size line.
// A stalled sink holds the result register; the input register still takes a
// word while the result waits, and further words stall only when both are full.
module http_chunked_body_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte
	input  logic        s_axis_tuser,  // restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [hcbd_pkg::M_DATA_BITS-1:0] m_axis_tdata, // data_byte, body_length, overflow
	output logic        m_axis_tuser,  // is_data
	output logic        m_axis_tlast
);

	hcbd_pkg::in_word_t  in_word;
	hcbd_pkg::in_word_t  word_s1;
	hcbd_pkg::res_word_t res;
	hcbd_pkg::res_word_t word_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic                room;
	logic                step;
	logic                res_valid;

	assign in_word.in_byte = s_axis_tdata;
	assign in_word.restart = s_axis_tuser;
	assign step            = valid_s1 && room;

	hcbd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_word  (in_word),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1),
		.take     (step)
	);

	hcbd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.word      (word_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	hcbd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res       (res),
		.room      (room),
		.valid_s2  (valid_s2),
		.word_s2   (word_s2),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = word_s2.is_data;
	assign m_axis_tlast  = word_s2.last;
	assign m_axis_tdata  = hcbd_pkg::M_DATA_BITS'({word_s2.overflow, word_s2.body_length,
		word_s2.data_byte});

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the HTTP chunked body decoder: directed table, then random messages.
module testbench;

	localparam logic [7:0] HT = 8'h09;
	localparam logic [7:0] LF = 8'h0a;
	localparam logic [7:0] VT = 8'h0b;
	localparam logic [7:0] FF = 8'h0c;
	localparam logic [7:0] CR = 8'h0d;
	localparam logic [7:0] SP = 8'h20;
	localparam logic [hcbd_pkg::SIZE_BITS-1:0] SIZE_MAX = '1;
	localparam logic [hcbd_pkg::LENGTH_BITS-1:0] LENGTH_MAX = '1;
	localparam int RANDOM_ITEMS = 1900;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic [2:0] {
		PH_BLANK,
		PH_LINE,
		PH_DATA,
		PH_TRAIL,
		PH_ENDWAIT,
		PH_DONE
	} dec_phase_t;

	typedef struct packed {
		logic [7:0]          ch;
		logic                rst;
		logic                typed;
		hcbd_pkg::res_word_t res;
	} row_t;

	localparam hcbd_pkg::res_word_t NONE = '0;

	// overflow, body_length, last, is_data, data_byte
	localparam row_t PLAN [32] = '{
		'{SP,    1'b1, 1'b0, NONE},
		'{"2",   1'b0, 1'b0, NONE},
		'{";",   1'b0, 1'b0, NONE},
		'{CR,    1'b0, 1'b0, NONE},
		'{LF,    1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b1, '{1'b0, 32'd1, 1'b0, 1'b1, 8'h00}},
		'{8'hff, 1'b0, 1'b1, '{1'b0, 32'd2, 1'b0, 1'b1, 8'hff}},
		'{"x",   1'b0, 1'b0, NONE},
		'{"y",   1'b0, 1'b0, NONE},
		'{"0",   1'b0, 1'b0, NONE},
		'{CR,    1'b0, 1'b0, NONE},
		'{CR,    1'b0, 1'b0, NONE},
		'{LF,    1'b0, 1'b0, NONE},
		'{"a",   1'b0, 1'b0, NONE},
		'{"b",   1'b0, 1'b1, '{1'b0, 32'd2, 1'b1, 1'b0, 8'h00}},
		'{HT,    1'b1, 1'b0, NONE},
		'{CR,    1'b0, 1'b0, NONE},
		'{LF,    1'b0, 1'b0, NONE},
		'{"q",   1'b0, 1'b0, NONE},
		'{"r",   1'b0, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0, 8'h00}},
		'{"f",   1'b1, 1'b0, NONE},
		'{"F",   1'b0, 1'b0, NONE},
		'{"f",   1'b0, 1'b0, NONE},
		'{"F",   1'b0, 1'b0, NONE},
		'{"f",   1'b0, 1'b0, NONE},
		'{"F",   1'b0, 1'b0, NONE},
		'{"f",   1'b0, 1'b0, NONE},
		'{"F",   1'b0, 1'b0, NONE},
		'{"f",   1'b0, 1'b0, NONE},
		'{CR,    1'b0, 1'b0, NONE},
		'{LF,    1'b0, 1'b0, NONE},
		'{"G",   1'b0, 1'b1, '{1'b1, 32'd1, 1'b0, 1'b1, "G"}}
	};

	localparam logic [7:0] BLANKS [5] = '{SP, HT, LF, VT, FF};

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [hcbd_pkg::M_DATA_BITS-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	http_chunked_body_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	row_t body_bytes[$];
	hcbd_pkg::res_word_t pending_results[$];
	row_t cur;
	bit fresh_msg;
	bit running = 1'b0;
	int words_in = 0;
	int fails = 0;
	int quiet_cycles = 0;

	dec_phase_t ph = PH_BLANK;
	logic [hcbd_pkg::SIZE_BITS-1:0] chunk_left = '0;
	bit got_digit = 1'b0;
	bit digits_shut = 1'b0;
	bit saw_cr = 1'b0;
	logic [1:0] skip_cnt = '0;
	logic [hcbd_pkg::LENGTH_BITS-1:0] byte_total = '0;
	bit size_ovf = 1'b0;

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic bit blank_char(logic [7:0] c);
		return c == SP || c == HT || c == LF || c == VT || c == FF || c == CR;
	endfunction

	function automatic logic [7:0] hex_char(int unsigned n);
		if (n < 10) return 8'("0" + n);
		return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
	endfunction

	task automatic clear_decoder();
		ph = PH_BLANK;
		chunk_left = '0;
		got_digit = 1'b0;
		digits_shut = 1'b0;
		saw_cr = 1'b0;
		skip_cnt = '0;
		byte_total = '0;
		size_ovf = 1'b0;
	endtask

	task automatic decode_byte(input row_t w, output bit produced,
		output hcbd_pkg::res_word_t r);
		int d;
		produced = 1'b0;
		r = '0;
		if (w.rst)
			clear_decoder();
		case (ph)
			PH_BLANK, PH_LINE: begin
				if (saw_cr && w.ch == LF) begin
					saw_cr = 1'b0;
					if (!got_digit || chunk_left == 0) begin
						ph = PH_ENDWAIT;
						skip_cnt = 2'd2;
					end else begin
						ph = PH_DATA;
					end
				end else begin
					saw_cr = (w.ch == CR);
					if (!(ph == PH_BLANK && blank_char(w.ch))) begin
						ph = PH_LINE;
						d = hex_nibble(w.ch);
						if (!digits_shut && d >= 0) begin
							got_digit = 1'b1;
							if (chunk_left > (SIZE_MAX >> 4)) begin
								chunk_left = SIZE_MAX;
								size_ovf = 1'b1;
							end else begin
								chunk_left = {chunk_left[hcbd_pkg::SIZE_BITS-5:0], 4'(d)};
							end
						end else begin
							digits_shut = 1'b1;
						end
					end
				end
			end
			PH_DATA: begin
				if (byte_total != LENGTH_MAX)
					byte_total++;
				produced = 1'b1;
				r.data_byte = w.ch;
				r.is_data = 1'b1;
				r.body_length = hcbd_pkg::BLEN_BITS'(byte_total);
				r.overflow = size_ovf;
				chunk_left--;
				if (chunk_left == 0) begin
					ph = PH_TRAIL;
					skip_cnt = 2'd2;
				end
			end
			PH_TRAIL: begin
				skip_cnt--;
				if (skip_cnt == 0) begin
					ph = PH_BLANK;
					chunk_left = '0;
					got_digit = 1'b0;
					digits_shut = 1'b0;
					saw_cr = 1'b0;
				end
			end
			PH_ENDWAIT: begin
				skip_cnt--;
				if (skip_cnt == 0) begin
					ph = PH_DONE;
					produced = 1'b1;
					r.last = 1'b1;
					r.body_length = hcbd_pkg::BLEN_BITS'(byte_total);
					r.overflow = size_ovf;
				end
			end
			default: ;
		endcase
	endtask

	task automatic take_word(input row_t w);
		bit produced;
		hcbd_pkg::res_word_t r;
		decode_byte(w, produced, r);
		if (w.typed)
			pending_results.push_back(w.res);
		else if (produced)
			pending_results.push_back(r);
	endtask

	task automatic push_char(logic [7:0] c);
		body_bytes.push_back('{c, fresh_msg, 1'b0, NONE});
		fresh_msg = 1'b0;
	endtask

	task automatic push_size(int unsigned v);
		int unsigned n;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0)
			n++;
		n += ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
		for (int i = n - 1; i >= 0; i--)
			push_char(hex_char((v >> (4 * i)) & 15));
	endtask

	task automatic push_line_tail();
		int unsigned k;
		if ($urandom_range(3) == 0) begin
			push_char(";");
			k = $urandom_range(4);
			repeat (k)
				push_char(8'($urandom_range(8'h21, 8'h7e)));
		end
		if ($urandom_range(9) == 0) begin
			push_char(CR);
			push_char("x");
		end
		push_char(CR);
		push_char(LF);
	endtask

	task automatic push_message();
		int unsigned kind, chunks, sz, k;
		fresh_msg = 1'b1;
		kind = $urandom_range(99);
		if (kind < 75) begin
			chunks = $urandom_range(3);
			repeat (chunks) begin
				k = $urandom_range(2);
				repeat (k)
					push_char(BLANKS[$urandom_range(4)]);
				sz = ($urandom_range(9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
				push_size(sz);
				push_line_tail();
				repeat (sz)
					push_char(8'($urandom));
				push_char(8'($urandom));
				push_char(8'($urandom));
			end
			if ($urandom_range(6) != 0) begin
				k = $urandom_range(1, 3);
				repeat (k)
					push_char("0");
			end
			push_line_tail();
			push_char(8'($urandom));
			push_char(8'($urandom));
			if ($urandom_range(3) == 0) begin
				k = $urandom_range(1, 3);
				repeat (k)
					push_char(8'($urandom));
			end
		end else if (kind < 85) begin
			push_char(hex_char($urandom_range(1, 15)));
			k = $urandom_range(8, 10);
			repeat (k)
				push_char(hex_char($urandom_range(15)));
			push_line_tail();
			k = $urandom_range(10);
			repeat (k)
				push_char(8'($urandom));
		end else begin
			k = $urandom_range(1, 30);
			repeat (k)
				push_char(8'($urandom));
		end
	endtask

	wire calm = words_in >= 600 && words_in < 1000;

	always @(posedge clk) begin
		if (running) begin
			if (s_axis_tvalid && s_axis_tready) begin
				take_word(cur);
				words_in <= words_in + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (body_bytes.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
					cur = body_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= cur.ch;
					s_axis_tuser <= cur.rst;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		hcbd_pkg::res_word_t want;
		if (running) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected");
					fails++;
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tdata[7:0] !== want.data_byte) begin
						$error("data_byte: expected %0h, got %0h", want.data_byte, m_axis_tdata[7:0]);
						fails++;
					end
					if (m_axis_tuser !== want.is_data) begin
						$error("is_data: expected %0b, got %0b", want.is_data, m_axis_tuser);
						fails++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, m_axis_tlast);
						fails++;
					end
					if (m_axis_tdata[39:8] !== want.body_length) begin
						$error("body_length: expected %0d, got %0d", want.body_length,
							m_axis_tdata[39:8]);
						fails++;
					end
					if (m_axis_tdata[40] !== want.overflow) begin
						$error("overflow: expected %0b, got %0b", want.overflow, m_axis_tdata[40]);
						fails++;
					end
				end
			end
			m_axis_tready <= calm || $urandom_range(99) >= 33;
		end
	end

	always @(posedge clk) begin
		if (running) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		foreach (PLAN[i])
			body_bytes.push_back(PLAN[i]);
		while (body_bytes.size() < $size(PLAN) + RANDOM_ITEMS)
			push_message();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		running <= 1'b1;
		@(negedge clk);
		while (body_bytes.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
